@@ hw/rtl/hrsp_pkg.sv @@
`default_nettype none
package hrsp_pkg;

    // Special bytes
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    // Parse phases
    localparam logic [1:0] PH_REQ  = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // Request line fields
    localparam logic [1:0] FLD_METHOD  = 2'd0;
    localparam logic [1:0] FLD_PATH    = 2'd1;
    localparam logic [1:0] FLD_VERSION = 2'd2;
    localparam logic [1:0] FLD_DONE    = 2'd3;

    // Match position marks
    localparam logic [4:0] POS_MAX    = 5'd31;
    localparam logic [4:0] DEAD_LINE  = 5'd31;
    localparam logic [4:0] PREFIX_LEN = 5'd15;
    localparam logic [4:0] VER_STEM   = 5'd7;
    localparam logic [4:0] LEN_GET    = 5'd3;
    localparam logic [4:0] LEN_POST   = 5'd4;
    localparam logic [4:0] LEN_HEAD   = 5'd4;

    // Result kinds and codes
    localparam logic       KIND_KEY  = 1'b0;
    localparam logic       KIND_DONE = 1'b1;
    localparam logic [1:0] METHOD_NONE = 2'd0;
    localparam logic [1:0] METHOD_GET  = 2'd1;
    localparam logic [1:0] METHOD_POST = 2'd2;
    localparam logic [1:0] METHOD_HEAD = 2'd3;
    localparam logic [1:0] VER_NONE = 2'd0;
    localparam logic [1:0] VER_10   = 2'd1;
    localparam logic [1:0] VER_11   = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  key;
        logic [1:0]  method;
        logic [1:0]  version;
        logic [31:0] length;
        logic        overflow;
        logic        key_empty;
    } res_t;

    function automatic logic [7:0] get_char(input logic [1:0] pos);
        case (pos)
            2'd0:    get_char = "G";
            2'd1:    get_char = "E";
            2'd2:    get_char = "T";
            default: get_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] post_char(input logic [1:0] pos);
        case (pos)
            2'd0:    post_char = "P";
            2'd1:    post_char = "O";
            2'd2:    post_char = "S";
            default: post_char = "T";
        endcase
    endfunction

    function automatic logic [7:0] head_char(input logic [1:0] pos);
        case (pos)
            2'd0:    head_char = "H";
            2'd1:    head_char = "E";
            2'd2:    head_char = "A";
            default: head_char = "D";
        endcase
    endfunction

    // "HTTP/1." stem
    function automatic logic [7:0] ver_char(input logic [2:0] pos);
        case (pos)
            3'd0:    ver_char = "H";
            3'd1:    ver_char = "T";
            3'd2:    ver_char = "T";
            3'd3:    ver_char = "P";
            3'd4:    ver_char = "/";
            3'd5:    ver_char = "1";
            3'd6:    ver_char = ".";
            default: ver_char = 8'h00;
        endcase
    endfunction

    // "CONTENT-LENGTH:"
    function automatic logic [7:0] hdr_char(input logic [3:0] pos);
        case (pos)
            4'd0:    hdr_char = "C";
            4'd1:    hdr_char = "O";
            4'd2:    hdr_char = "N";
            4'd3:    hdr_char = "T";
            4'd4:    hdr_char = "E";
            4'd5:    hdr_char = "N";
            4'd6:    hdr_char = "T";
            4'd7:    hdr_char = "-";
            4'd8:    hdr_char = "L";
            4'd9:    hdr_char = "E";
            4'd10:   hdr_char = "N";
            4'd11:   hdr_char = "G";
            4'd12:   hdr_char = "T";
            4'd13:   hdr_char = "H";
            4'd14:   hdr_char = ":";
            default: hdr_char = 8'h00;
        endcase
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/http_request_stream_parser_top.sv @@
// Result beats are registered in the output register or, on a stall, in the skid stage.
// Throughput: one input beat per cycle while s_ready is high, one registered pass per byte.
// An output register plus a one-entry skid stage let input beats keep flowing while a
// result waits; s_ready drops only while the skid stage holds a result.
// Reset: synchronous, active-low aresetn clears the parser state and both result valid flags.
`default_nettype none
module http_request_stream_parser_top
    import hrsp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output      logic        s_ready,
    input  wire logic [7:0]  s_data_byte,
    output      logic        m_valid,
    input  wire logic        m_ready,
    output      logic        m_result_kind,
    output      logic [7:0]  m_key_byte,
    output      logic [1:0]  m_method_code,
    output      logic [1:0]  m_version_code,
    output      logic [31:0] m_body_length,
    output      logic        m_length_overflow,
    output      logic        m_key_was_empty
);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // Parser state
    logic [1:0]             phase_reg, phase_next;
    logic [1:0]             field_reg, field_next;
    logic [4:0]             pos_reg, pos_next;
    logic [2:0]             mcand_reg, mcand_next;
    logic [1:0]             vcand_reg, vcand_next;
    logic [1:0]             method_reg, method_next;
    logic [1:0]             version_reg, version_next;
    logic                   prev_cr_reg, prev_cr_next;
    logic                   line_start_reg, line_start_next;
    logic                   len_active_reg, len_active_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [LENGTH_BITS-1:0] remain_reg, remain_next;
    logic                   ovf_reg, ovf_next;
    logic                   key_empty_reg, key_empty_next;

    // Result stages
    res_t out_reg;
    logic out_valid_reg;
    res_t skid_reg;
    logic skid_valid_reg;

    logic in_accept;
    logic has_res;
    res_t res;
    logic [LENGTH_BITS+31:0] acc_ext;

    assign s_ready   = !skid_valid_reg;
    assign in_accept = s_valid && s_ready;
    // Report the low 32 bits of the counter, zero-extended when the counter is narrower
    assign acc_ext   = {32'd0, acc_reg};

    always_comb begin
        logic [7:0]             up;
        logic [LENGTH_BITS+3:0] scaled;
        logic                   restart;
        logic                   is_cr;
        logic [1:0]             vc;

        up = (s_data_byte inside {["a":"z"]}) ? (s_data_byte - 8'd32) : s_data_byte;
        // acc * 10 + digit, with four spare bits to spot overflow
        scaled = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
               + {{LENGTH_BITS{1'b0}}, s_data_byte[3:0]};
        is_cr   = (s_data_byte == CHAR_CR);
        restart = 1'b0;
        vc      = vcand_reg;

        phase_next      = phase_reg;
        field_next      = field_reg;
        pos_next        = pos_reg;
        mcand_next      = mcand_reg;
        vcand_next      = vcand_reg;
        method_next     = method_reg;
        version_next    = version_reg;
        prev_cr_next    = prev_cr_reg;
        line_start_next = line_start_reg;
        len_active_next = len_active_reg;
        acc_next        = acc_reg;
        remain_next     = remain_reg;
        ovf_next        = ovf_reg;
        key_empty_next  = key_empty_reg;
        has_res         = 1'b0;
        res             = '0;

        if (in_accept) begin
            if (phase_reg == PH_BODY) begin
                // Skip body bytes; the last one completes the request
                if (remain_reg != '0) begin
                    remain_next = remain_reg - LENGTH_BITS'(1);
                end
                if (remain_next == '0) begin
                    restart = 1'b1;
                end
            end else if (s_data_byte == CHAR_LF && prev_cr_reg) begin
                // Line end
                prev_cr_next    = 1'b0;
                line_start_next = 1'b1;
                pos_next        = '0;
                len_active_next = 1'b0;
                if (phase_reg == PH_REQ) begin
                    phase_next = PH_HDR;
                end else if (line_start_reg) begin
                    // Empty line: body starts, or the request completes here if the length is zero
                    remain_next = acc_reg;
                    if (acc_reg == '0) begin
                        restart = 1'b1;
                    end else begin
                        phase_next = PH_BODY;
                    end
                end
            end else begin
                line_start_next = line_start_reg && !prev_cr_reg && is_cr;
                prev_cr_next    = is_cr;
                if (phase_reg == PH_REQ) begin
                    case (field_reg)
                        FLD_METHOD: begin
                            if (s_data_byte == CHAR_SPACE) begin
                                // First live candidate whose whole name was seen
                                if (mcand_reg[0] && pos_reg >= LEN_GET) begin
                                    method_next = METHOD_GET;
                                end else if (mcand_reg[1] && pos_reg >= LEN_POST) begin
                                    method_next = METHOD_POST;
                                end else if (mcand_reg[2] && pos_reg >= LEN_HEAD) begin
                                    method_next = METHOD_HEAD;
                                end else begin
                                    method_next = METHOD_NONE;
                                end
                                field_next = FLD_PATH;
                                pos_next   = '0;
                            end else begin
                                if (pos_reg < LEN_GET && up != get_char(pos_reg[1:0])) begin
                                    mcand_next[0] = 1'b0;
                                end
                                if (pos_reg < LEN_POST && up != post_char(pos_reg[1:0])) begin
                                    mcand_next[1] = 1'b0;
                                end
                                if (pos_reg < LEN_HEAD && up != head_char(pos_reg[1:0])) begin
                                    mcand_next[2] = 1'b0;
                                end
                                if (pos_reg < POS_MAX) begin
                                    pos_next = pos_reg + 5'd1;
                                end
                            end
                        end
                        FLD_PATH: begin
                            if (pos_reg == '0) begin
                                // Drop the first path byte (the leading slash) without checking it
                                pos_next = 5'd1;
                            end else if (s_data_byte == CHAR_SPACE || is_cr) begin
                                field_next = FLD_VERSION;
                                pos_next   = '0;
                            end else begin
                                key_empty_next = 1'b0;
                                has_res        = 1'b1;
                                res.kind       = KIND_KEY;
                                res.key        = s_data_byte;
                            end
                        end
                        FLD_VERSION: begin
                            if (pos_reg < VER_STEM) begin
                                if (up != ver_char(pos_reg[2:0])) begin
                                    vc = 2'b00;
                                end
                            end else begin
                                if (s_data_byte != CHAR_ONE) begin
                                    vc[0] = 1'b0;
                                end
                                if (s_data_byte != CHAR_ZERO) begin
                                    vc[1] = 1'b0;
                                end
                            end
                            vcand_next = vc;
                            pos_next   = pos_reg + 5'd1;
                            if (pos_reg >= VER_STEM) begin
                                version_next = vc[0] ? VER_11 : (vc[1] ? VER_10 : VER_NONE);
                                field_next   = FLD_DONE;
                                pos_next     = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    // Header line
                    if (len_active_reg) begin
                        if (is_cr) begin
                            len_active_next = 1'b0;
                        end else if ((s_data_byte inside {["0":"9"]}) && !ovf_reg) begin
                            if (scaled[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
                                acc_next = LEN_MAX;
                                ovf_next = 1'b1;
                            end else begin
                                acc_next = scaled[LENGTH_BITS-1:0];
                            end
                        end
                    end else if (pos_reg < PREFIX_LEN) begin
                        if (up == hdr_char(pos_reg[3:0])) begin
                            pos_next = pos_reg + 5'd1;
                            if (pos_next == PREFIX_LEN) begin
                                len_active_next = 1'b1;
                            end
                        end else begin
                            pos_next = DEAD_LINE;
                        end
                    end
                end
            end
        end

        if (restart) begin
            // Emit the completion beat from the current state, then start over
            has_res       = 1'b1;
            res.kind      = KIND_DONE;
            res.key       = 8'd0;
            res.method    = method_reg;
            res.version   = version_reg;
            res.length    = acc_ext[31:0];
            res.overflow  = ovf_reg;
            res.key_empty = key_empty_reg;

            phase_next      = PH_REQ;
            field_next      = FLD_METHOD;
            pos_next        = '0;
            mcand_next      = 3'b111;
            vcand_next      = 2'b11;
            method_next     = METHOD_NONE;
            version_next    = VER_NONE;
            prev_cr_next    = 1'b0;
            line_start_next = 1'b1;
            len_active_next = 1'b0;
            acc_next        = '0;
            remain_next     = '0;
            ovf_next        = 1'b0;
            key_empty_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_REQ;
            field_reg      <= FLD_METHOD;
            pos_reg        <= '0;
            mcand_reg      <= 3'b111;
            vcand_reg      <= 2'b11;
            method_reg     <= METHOD_NONE;
            version_reg    <= VER_NONE;
            prev_cr_reg    <= 1'b0;
            line_start_reg <= 1'b1;
            len_active_reg <= 1'b0;
            acc_reg        <= '0;
            remain_reg     <= '0;
            ovf_reg        <= 1'b0;
            key_empty_reg  <= 1'b1;
        end else begin
            phase_reg      <= phase_next;
            field_reg      <= field_next;
            pos_reg        <= pos_next;
            mcand_reg      <= mcand_next;
            vcand_reg      <= vcand_next;
            method_reg     <= method_next;
            version_reg    <= version_next;
            prev_cr_reg    <= prev_cr_next;
            line_start_reg <= line_start_next;
            len_active_reg <= len_active_next;
            acc_reg        <= acc_next;
            remain_reg     <= remain_next;
            ovf_reg        <= ovf_next;
            key_empty_reg  <= key_empty_next;
        end
    end

    // Result stage control: the output register takes a new result when it is free or
    // being drained; otherwise the result parks in the skid stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (has_res) begin
            if (out_valid_reg && !m_ready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload: no reset
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (has_res) begin
            if (out_valid_reg && !m_ready) begin
                skid_reg <= res;
            end else begin
                out_reg <= res;
            end
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_result_kind     = out_reg.kind;
    assign m_key_byte        = out_reg.key;
    assign m_method_code     = out_reg.method;
    assign m_version_code    = out_reg.version;
    assign m_body_length     = out_reg.length;
    assign m_length_overflow = out_reg.overflow;
    assign m_key_was_empty   = out_reg.key_empty;

`ifndef SYNTHESIS
    // A parked result always has one ahead of it in the output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds a beat while output register is empty");

    // Body skipping never idles with nothing left to skip
    a_body_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_BODY) |-> (remain_reg != '0))
        else $error("body phase with zero bytes remaining");

    // Digit scan only runs in a header line whose prefix fully matched
    a_len_active: assert property (@(posedge aclk) disable iff (!aresetn)
        len_active_reg |-> (phase_reg == PH_HDR && pos_reg == PREFIX_LEN))
        else $error("length scan active outside a matched header line");

    // Overflow pins the counter at its maximum
    a_ovf_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        ovf_reg |-> (acc_reg == LEN_MAX))
        else $error("overflow flag set without saturated counter");
`endif

endmodule
`default_nettype wire
